// ----- src/uedma_pkg.sv -----
// shared types, constants and codes for the usb endpoint dma scheduler
package uedma_pkg;

    localparam int ENDPOINTS  = 8;
    localparam int MAX_PACKET = 64;
    localparam int EP_W       = 3;
    localparam int LEN_W      = 16;
    localparam int PS_W       = 7;

    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_CLOSE = 3'd1,
        OP_START = 3'd2,
        OP_READY = 3'd3,
        OP_DMA   = 3'd4,
        OP_SETUP = 3'd5,
        OP_RESET = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        K_ACCEPT  = 3'd0,
        K_REJECT  = 3'd1,
        K_DONE    = 3'd2,
        K_DMA     = 3'd3,
        K_STATUS  = 3'd4,
        K_RECEIVE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_SERVE,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [EP_W-1:0]  ep;
        logic             dir;
        logic [LEN_W-1:0] len;
    } result_t;

endpackage

// ----- src/uedma_minsub.sv -----
// shared subtract and compare unit: remainder and chunk size
module uedma_minsub
    import uedma_pkg::*;
(
    input  logic [LEN_W-1:0] a,
    input  logic [LEN_W-1:0] b,
    input  logic [PS_W-1:0]  cap,
    output logic             a_lt_b,
    output logic [LEN_W-1:0] chunk
);
    logic [LEN_W-1:0] diff;

    always_comb begin
        diff   = b - a;
        a_lt_b = (a < b);
        if (diff < LEN_W'(cap)) begin
            chunk = diff;
        end else begin
            chunk = LEN_W'(cap);
        end
    end
endmodule

// ----- src/usb_endpoint_dma_scheduler.sv -----
// usb endpoint dma scheduler top level: event sequencer and transfer records
//  channel | dir | tdata (low bit up)                    | tuser
//  s_      | in  | endpoint[3] dir_in[1] length[16] pad  | operation[3]
//  m_      | out | out_endpoint[3] out_dir_in[1] len[16] | kind[3]; tlast = last
// each event passes the idle state where it is accepted, the event state that
// decodes it, the serve state with its arbitration steps (clear for bus reset),
// then the emit state that sends its results in turn while the output is not stalled
// bus reset walks the 16 transfer records, one per cycle
// s_tready is low from acceptance until the final result is taken, or until serve or clear ends if none
module usb_endpoint_dma_scheduler
    import uedma_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // endpoint, dir_in, length, zero pad
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_endpoint, out_dir_in, out_length, zero pad
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);
    localparam int REC = 2 * ENDPOINTS;
    localparam int RI_W = $clog2(REC);

    state_t state_reg, state_next;

    logic [LEN_W-1:0] total_reg [REC];
    logic [LEN_W-1:0] done_reg  [REC];
    logic [PS_W-1:0]  psize_reg [REC];
    logic [PS_W-1:0]  rx_reg    [ENDPOINTS];
    logic [REC-1:0]       started_reg;
    logic [ENDPOINTS-1:0] waiting_reg, pend_out_reg, pend_in_reg;
    logic status_reg, receive_reg, busy_reg, setup_in_reg;

    logic [2:0]       op_reg;
    logic [EP_W-1:0]  ep_reg;
    logic             dir_reg;
    logic [LEN_W-1:0] len_reg;

    result_t res_q_reg [5];
    logic [2:0] res_cnt_reg, res_rd_reg;
    logic       serve_done_reg;
    logic [RI_W-1:0] clr_reg;

    logic s_acc, m_acc;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // shared unit operands
    logic [RI_W-1:0]  u_idx;
    logic [LEN_W-1:0] u_a, u_b;
    logic [PS_W-1:0]  u_cap;
    logic             u_lt;
    logic [LEN_W-1:0] u_chunk;

    uedma_minsub u_ms (.a(u_a), .b(u_b), .cap(u_cap), .a_lt_b(u_lt), .chunk(u_chunk));

    logic [RI_W-1:0] ev_idx;
    logic ep_ok;
    assign ev_idx = {ep_reg, dir_reg};
    assign ep_ok  = ({1'b0, ep_reg} < 4'(ENDPOINTS));

    // lowest pending endpoints
    logic out_any, in_any;
    logic [EP_W-1:0] out_lo, in_lo;
    always_comb begin
        out_any = 1'b0; in_any = 1'b0; out_lo = '0; in_lo = '0;
        for (int i = ENDPOINTS - 1; i >= 0; i--) begin
            if (pend_out_reg[i]) begin
                out_any = 1'b1; out_lo = EP_W'(i);
            end
            if (pend_in_reg[i]) begin
                in_any = 1'b1; in_lo = EP_W'(i);
            end
        end
    end

    // dma end sum
    logic [LEN_W:0]   dsum;
    logic [LEN_W-1:0] dsat;
    always_comb begin
        dsum = {1'b0, done_reg[ev_idx]} + {1'b0, len_reg};
        dsat = dsum[LEN_W] ? '1 : dsum[LEN_W-1:0];
    end

    always_comb begin
        u_idx = ev_idx;
        u_a   = done_reg[ev_idx];
        u_cap = rx_reg[ep_reg];
        if (state_reg == ST_SERVE) begin
            if (out_any) begin
                u_idx = {out_lo, 1'b0};
                u_cap = rx_reg[out_lo];
            end else begin
                u_idx = {in_lo, 1'b1};
                u_cap = psize_reg[{in_lo, 1'b1}];
            end
            u_a = done_reg[u_idx];
        end else if (op_reg == OP_DMA) begin
            u_a = dsat;
        end
        u_b = total_reg[u_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_acc) state_next = ST_EVENT;
            ST_EVENT: state_next = (op_reg == OP_RESET) ? ST_CLEAR : ST_SERVE;
            ST_SERVE: if (serve_done_reg) state_next = (res_cnt_reg != 0) ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (m_acc && res_rd_reg + 3'd1 == res_cnt_reg) state_next = ST_IDLE;
            ST_CLEAR: if (clr_reg == RI_W'(REC - 1)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    function automatic result_t mk(input logic [2:0] k, input logic [EP_W-1:0] e,
                                   input logic d, input logic [LEN_W-1:0] l);
        result_t r;
        r.kind = k; r.ep = e; r.dir = d; r.len = l;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            started_reg <= '0; waiting_reg <= '0; pend_out_reg <= '0; pend_in_reg <= '0;
            status_reg <= 1'b0; receive_reg <= 1'b0; busy_reg <= 1'b0; setup_in_reg <= 1'b0;
            res_cnt_reg <= '0; res_rd_reg <= '0; serve_done_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg  <= s_tuser;
                        ep_reg  <= s_tdata[2:0];
                        dir_reg <= s_tdata[3];
                        len_reg <= s_tdata[19:4];
                        res_cnt_reg <= '0; res_rd_reg <= '0; serve_done_reg <= 1'b0;
                    end
                end
                ST_EVENT: begin
                    case (op_reg)
                        OP_OPEN: begin
                            if (!ep_ok || ep_reg == '0 || len_reg == '0 ||
                                len_reg > LEN_W'(MAX_PACKET)) begin
                                res_q_reg[0] <= mk(K_REJECT, ep_reg, dir_reg, '0);
                            end else begin
                                psize_reg[ev_idx] <= len_reg[PS_W-1:0];
                                started_reg[ev_idx] <= 1'b0;
                                if (!dir_reg) begin
                                    waiting_reg[ep_reg] <= 1'b0;
                                    rx_reg[ep_reg] <= '0;
                                end
                                res_q_reg[0] <= mk(K_ACCEPT, ep_reg, dir_reg, '0);
                            end
                            res_cnt_reg <= 3'd1;
                        end
                        OP_CLOSE: begin
                            if (!ep_ok || ep_reg == '0) begin
                                res_q_reg[0] <= mk(K_REJECT, ep_reg, dir_reg, '0);
                            end else begin
                                if (dir_reg) begin
                                    pend_in_reg[ep_reg] <= 1'b0;
                                end else begin
                                    pend_out_reg[ep_reg] <= 1'b0;
                                    waiting_reg[ep_reg] <= 1'b0;
                                    rx_reg[ep_reg] <= '0;
                                end
                                started_reg[ev_idx] <= 1'b0;
                                done_reg[ev_idx] <= '0;
                                total_reg[ev_idx] <= '0;
                                psize_reg[ev_idx] <= '0;
                                res_q_reg[0] <= mk(K_ACCEPT, ep_reg, dir_reg, '0);
                            end
                            res_cnt_reg <= 3'd1;
                        end
                        OP_START: begin
                            if (!ep_ok || started_reg[ev_idx] || psize_reg[ev_idx] == '0) begin
                                res_q_reg[0] <= mk(K_REJECT, ep_reg, dir_reg, '0);
                                res_cnt_reg <= 3'd1;
                            end else begin
                                res_q_reg[0] <= mk(K_ACCEPT, ep_reg, dir_reg, '0);
                                total_reg[ev_idx] <= len_reg;
                                done_reg[ev_idx] <= '0;
                                if (ep_reg == '0 && len_reg == '0 && dir_reg != setup_in_reg) begin
                                    started_reg[ev_idx] <= 1'b0;
                                    res_q_reg[1] <= mk(K_DONE, '0, dir_reg, '0);
                                    res_cnt_reg <= 3'd2;
                                    status_reg <= 1'b1;
                                end else begin
                                    started_reg[ev_idx] <= 1'b1;
                                    res_cnt_reg <= 3'd1;
                                    if (dir_reg) begin
                                        pend_in_reg[ep_reg] <= 1'b1;
                                    end else if (ep_reg == '0) begin
                                        receive_reg <= 1'b1;
                                    end else if (waiting_reg[ep_reg]) begin
                                        waiting_reg[ep_reg] <= 1'b0;
                                        pend_out_reg[ep_reg] <= 1'b1;
                                    end
                                end
                            end
                        end
                        OP_READY: begin
                            if (ep_ok) begin
                                rx_reg[ep_reg] <= (len_reg > LEN_W'(MAX_PACKET)) ?
                                    PS_W'(MAX_PACKET) : len_reg[PS_W-1:0];
                                if (started_reg[{ep_reg, 1'b0}] &&
                                    (done_reg[{ep_reg, 1'b0}] < total_reg[{ep_reg, 1'b0}] ||
                                     total_reg[{ep_reg, 1'b0}] == '0)) begin
                                    waiting_reg[ep_reg] <= 1'b0;
                                    pend_out_reg[ep_reg] <= 1'b1;
                                end else begin
                                    waiting_reg[ep_reg] <= 1'b1;
                                end
                            end
                        end
                        OP_DMA: begin
                            busy_reg <= 1'b0;
                            if (ep_ok && started_reg[ev_idx]) begin
                                done_reg[ev_idx] <= dsat;
                                if (dir_reg) begin
                                    if (u_lt) begin
                                        pend_in_reg[ep_reg] <= 1'b1;
                                    end else begin
                                        started_reg[ev_idx] <= 1'b0;
                                        res_q_reg[0] <= mk(K_DONE, ep_reg, 1'b1, dsat);
                                        res_cnt_reg <= 3'd1;
                                    end
                                end else if (len_reg == LEN_W'(psize_reg[ev_idx]) && u_lt) begin
                                    if (ep_reg == '0) receive_reg <= 1'b1;
                                end else begin
                                    started_reg[ev_idx] <= 1'b0;
                                    res_q_reg[0] <= mk(K_DONE, ep_reg, 1'b0, dsat);
                                    res_cnt_reg <= 3'd1;
                                end
                            end
                        end
                        OP_SETUP: setup_in_reg <= dir_reg;
                        OP_RESET: begin
                            clr_reg <= '0;
                            started_reg <= '0; waiting_reg <= '0;
                            pend_out_reg <= '0; pend_in_reg <= '0;
                            status_reg <= 1'b0; receive_reg <= 1'b0;
                            busy_reg <= 1'b0; setup_in_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_SERVE: begin
                    // one arbitration step per cycle
                    if (!serve_done_reg) begin
                        if (busy_reg) begin
                            serve_done_reg <= 1'b1;
                        end else if (status_reg) begin
                            status_reg <= 1'b0;
                            res_q_reg[res_cnt_reg] <= mk(K_STATUS, '0, 1'b0, '0);
                            res_cnt_reg <= res_cnt_reg + 3'd1;
                        end else if (receive_reg) begin
                            receive_reg <= 1'b0;
                            res_q_reg[res_cnt_reg] <= mk(K_RECEIVE, '0, 1'b0, '0);
                            res_cnt_reg <= res_cnt_reg + 3'd1;
                        end else if (out_any || in_any) begin
                            if (out_any) pend_out_reg[out_lo] <= 1'b0;
                            else         pend_in_reg[in_lo] <= 1'b0;
                            if (started_reg[u_idx] && !(u_b < u_a)) begin
                                busy_reg <= 1'b1;
                                serve_done_reg <= 1'b1;
                                res_q_reg[res_cnt_reg] <= mk(K_DMA, u_idx[RI_W-1:1],
                                                             u_idx[0], u_chunk);
                                res_cnt_reg <= res_cnt_reg + 3'd1;
                            end
                        end else begin
                            serve_done_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT: if (m_acc) res_rd_reg <= res_rd_reg + 3'd1;
                ST_CLEAR: begin
                    total_reg[clr_reg] <= '0;
                    done_reg[clr_reg]  <= '0;
                    psize_reg[clr_reg] <= (clr_reg[RI_W-1:1] == '0) ? PS_W'(MAX_PACKET) : '0;
                    rx_reg[clr_reg[RI_W-1:1]] <= '0;
                    clr_reg <= clr_reg + RI_W'(1);
                end
                default: ;
            endcase
        end
    end

    result_t cur;
    assign cur      = res_q_reg[res_rd_reg];
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tuser  = cur.kind;
    assign m_tdata  = {4'b0, cur.len, cur.dir, cur.ep};
    assign m_tlast  = (res_rd_reg + 3'd1 == res_cnt_reg);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while results pending");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_rd_reg < res_cnt_reg) else $error("read past result queue");
    a_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |=> s_tready) else $error("not idle after last result");
`endif
endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the usb endpoint dma scheduler event stream
module testbench;
    import uedma_pkg::*;

    localparam int NEP = ENDPOINTS;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    usb_endpoint_dma_scheduler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  ep;
        logic        dir;
        logic [15:0] len;
        logic        last;
    } sched_result_t;

    // transfer records mirrored from the block
    logic [15:0] xfer_total [NEP][2];
    logic [15:0] xfer_done  [NEP][2];
    logic [6:0]  xfer_mps   [NEP][2];
    logic [15:0] xfer_started;
    logic [7:0]  rx_waiting;
    logic [6:0]  rx_size [NEP];
    logic [7:0]  out_pend;
    logic [7:0]  in_pend;
    logic        f_status, f_receive, f_busy, f_setup_in;

    sched_result_t results_due[$];
    sched_result_t event_res[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    function automatic void push_res(logic [2:0] k, logic [2:0] e, logic d, logic [15:0] l);
        sched_result_t r;
        if (event_res.size() >= 5) return;
        r.kind = k; r.ep = e; r.dir = d; r.len = l; r.last = 1'b0;
        event_res.push_back(r);
    endfunction

    function automatic void model_clear();
        for (int i = 0; i < NEP; i++) begin
            for (int d = 0; d < 2; d++) begin
                xfer_total[i][d] = '0;
                xfer_done[i][d] = '0;
                xfer_mps[i][d] = (i == 0) ? 7'(MAX_PACKET) : 7'd0;
            end
            rx_size[i] = '0;
        end
        xfer_started = '0; rx_waiting = '0; out_pend = '0; in_pend = '0;
        f_status = 0; f_receive = 0; f_busy = 0; f_setup_in = 0;
    endfunction

    function automatic int lowest_set(logic [7:0] m);
        for (int i = 0; i < NEP; i++)
            if (m[i]) return i;
        return -1;
    endfunction

    function automatic void serve_dma();
        int e;
        logic [15:0] rem;
        forever begin
            if (f_busy) return;
            if (f_status) begin
                f_status = 0;
                push_res(K_STATUS, 0, 0, 0);
                continue;
            end
            if (f_receive) begin
                f_receive = 0;
                push_res(K_RECEIVE, 0, 0, 0);
                continue;
            end
            e = lowest_set(out_pend);
            if (e >= 0) begin
                out_pend[e] = 0;
                if (xfer_started[e*2] && xfer_done[e][0] <= xfer_total[e][0]) begin
                    rem = xfer_total[e][0] - xfer_done[e][0];
                    push_res(K_DMA, 3'(e), 0, ({9'd0, rx_size[e]} < rem) ?
                             {9'd0, rx_size[e]} : rem);
                    f_busy = 1;
                    return;
                end
                continue;
            end
            e = lowest_set(in_pend);
            if (e >= 0) begin
                in_pend[e] = 0;
                if (xfer_started[e*2+1] && xfer_done[e][1] <= xfer_total[e][1]) begin
                    rem = xfer_total[e][1] - xfer_done[e][1];
                    push_res(K_DMA, 3'(e), 1, (rem < {9'd0, xfer_mps[e][1]}) ?
                             rem : {9'd0, xfer_mps[e][1]});
                    f_busy = 1;
                    return;
                end
                continue;
            end
            return;
        end
    endfunction

    function automatic void predict_event(op_t op, logic [2:0] e, logic d, logic [15:0] l);
        logic ok;
        int sb;
        logic [16:0] sum;
        ok = (e < NEP);
        sb = e * 2 + d;
        event_res.delete();
        case (op)
            OP_OPEN: begin
                if (!ok || e == 0 || l == 0 || l > MAX_PACKET) push_res(K_REJECT, e, d, 0);
                else begin
                    xfer_mps[e][d] = l[6:0];
                    xfer_started[sb] = 0;
                    if (!d) begin rx_waiting[e] = 0; rx_size[e] = 0; end
                    push_res(K_ACCEPT, e, d, 0);
                end
            end
            OP_CLOSE: begin
                if (!ok || e == 0) push_res(K_REJECT, e, d, 0);
                else begin
                    if (d) in_pend[e] = 0;
                    else begin out_pend[e] = 0; rx_waiting[e] = 0; rx_size[e] = 0; end
                    xfer_started[sb] = 0;
                    xfer_done[e][d] = 0; xfer_total[e][d] = 0; xfer_mps[e][d] = 0;
                    push_res(K_ACCEPT, e, d, 0);
                end
            end
            OP_START: begin
                if (!ok || xfer_started[sb] || xfer_mps[e][d] == 0) push_res(K_REJECT, e, d, 0);
                else begin
                    push_res(K_ACCEPT, e, d, 0);
                    xfer_total[e][d] = l; xfer_done[e][d] = 0; xfer_started[sb] = 1;
                    if (e == 0 && l == 0 && d != f_setup_in) begin
                        xfer_started[sb] = 0;
                        push_res(K_DONE, 0, d, 0);
                        f_status = 1;
                    end else if (d) in_pend[e] = 1;
                    else if (e == 0) f_receive = 1;
                    else if (rx_waiting[e]) begin
                        rx_waiting[e] = 0; out_pend[e] = 1;
                    end
                end
            end
            OP_READY: begin
                if (ok) begin
                    rx_size[e] = (l > MAX_PACKET) ? 7'(MAX_PACKET) : l[6:0];
                    if (xfer_started[e*2] && (xfer_done[e][0] < xfer_total[e][0] ||
                                              xfer_total[e][0] == 0)) begin
                        rx_waiting[e] = 0; out_pend[e] = 1;
                    end else rx_waiting[e] = 1;
                end
            end
            OP_DMA: begin
                f_busy = 0;
                if (ok && xfer_started[sb]) begin
                    sum = {1'b0, xfer_done[e][d]} + {1'b0, l};
                    xfer_done[e][d] = sum[16] ? 16'hFFFF : sum[15:0];
                    if (d) begin
                        if (xfer_done[e][1] < xfer_total[e][1]) in_pend[e] = 1;
                        else begin
                            xfer_started[sb] = 0;
                            push_res(K_DONE, e, 1, xfer_done[e][1]);
                        end
                    end else begin
                        if (l == {9'd0, xfer_mps[e][0]} && xfer_done[e][0] < xfer_total[e][0]) begin
                            if (e == 0) f_receive = 1;
                        end else begin
                            xfer_started[sb] = 0;
                            push_res(K_DONE, e, 0, xfer_done[e][0]);
                        end
                    end
                end
            end
            OP_SETUP: f_setup_in = d;
            OP_RESET: model_clear();
            default: ;
        endcase
        serve_dma();
        if (event_res.size() > 0) event_res[event_res.size()-1].last = 1'b1;
        foreach (event_res[i]) results_due.push_back(event_res[i]);
    endfunction

    task automatic send_event(op_t op, logic [2:0] e, logic d, logic [15:0] l);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, l, d, e};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_event(op, e, d, l);
        n_items++;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge aclk) begin
        sched_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (results_due.size() == 0) begin
                $error("unexpected result kind=%0d ep=%0d", m_tuser, m_tdata[2:0]);
                errors++;
            end else begin
                exp_r = results_due.pop_front();
                if (m_tuser !== exp_r.kind) begin
                    $error("kind: expected %0d actual %0d", exp_r.kind, m_tuser); errors++;
                end
                if (m_tdata[2:0] !== exp_r.ep) begin
                    $error("out_endpoint: expected %0d actual %0d", exp_r.ep, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[3] !== exp_r.dir) begin
                    $error("out_dir_in: expected %0d actual %0d", exp_r.dir, m_tdata[3]);
                    errors++;
                end
                if (m_tdata[19:4] !== exp_r.len) begin
                    $error("out_length: expected %0d actual %0d", exp_r.len, m_tdata[19:4]);
                    errors++;
                end
                if (m_tlast !== exp_r.last) begin
                    $error("last: expected %0d actual %0d", exp_r.last, m_tlast); errors++;
                end
            end
        end
    end

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_directed();
        send_event(OP_OPEN, 0, 0, 16);
        send_event(OP_OPEN, 3, 1, 0);
        send_event(OP_OPEN, 3, 1, 65);
        send_event(OP_OPEN, 7, 1, 64);
        send_event(OP_OPEN, 1, 0, 1);
        send_event(OP_OPEN, 2, 1, 8);
        send_event(OP_CLOSE, 0, 1, 0);
        send_event(OP_START, 5, 0, 10);
        send_event(OP_SETUP, 0, 1, 0);
        send_event(OP_START, 0, 0, 0);
        send_event(OP_START, 0, 1, 0);
        send_event(OP_SETUP, 0, 0, 0);
        send_event(OP_START, 0, 0, 100);
        send_event(OP_DMA, 0, 0, 64);
        send_event(OP_DMA, 0, 0, 36);
        send_event(OP_READY, 1, 1, 16'hFFFF);
        send_event(OP_START, 1, 0, 20);
        send_event(OP_START, 1, 0, 20);
        send_event(OP_DMA, 1, 0, 16'hFFFF);
        send_event(OP_START, 2, 1, 20);
        send_event(OP_DMA, 2, 1, 8);
        send_event(OP_DMA, 2, 1, 12);
        send_event(OP_NONE, 6, 1, 16'h5555);
        send_event(OP_CLOSE, 7, 1, 0);
        send_event(OP_RESET, 0, 0, 0);
    endtask

    // random events of all operation types on random endpoints, some with full-width lengths
    task automatic test_random(int count);
        logic [2:0] e;
        logic d;
        int p;
        for (int i = 0; i < count; i++) begin
            e = 3'($urandom_range(7));
            d = 1'($urandom_range(1));
            p = $urandom_range(99);
            if (p < 12) send_event(OP_OPEN, e, d, 16'($urandom_range(66)));
            else if (p < 30) send_event(OP_START, e, d, ($urandom_range(3) == 0) ?
                                        16'($urandom) : 16'($urandom_range(200)));
            else if (p < 45) send_event(OP_READY, e, d, ($urandom_range(4) == 0) ?
                                        16'($urandom) : 16'($urandom_range(64)));
            else if (p < 75) send_event(OP_DMA, e, d, ($urandom_range(5) == 0) ?
                                        16'($urandom) : 16'($urandom_range(64)));
            else if (p < 84) send_event(OP_SETUP, e, d, 16'($urandom));
            else if (p < 92) send_event(OP_CLOSE, e, d, 16'($urandom));
            else if (p < 96) send_event(OP_NONE, e, d, 16'($urandom));
            else if (p < 98) send_event(OP_RESET, e, d, 16'($urandom));
            else send_event(OP_OPEN, e, 0, 16'($urandom_range(1, 64)));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        test_random(20);
        drain_results();
        test_random(10);
    endtask

    initial begin
        model_clear();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (20) @(negedge aclk);
        send_idle_pct = 35; recv_idle_pct = 86;
        test_directed();
        drain_results();
        test_random(90);
        send_idle_pct = 86; recv_idle_pct = 35;
        test_random(90);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(70);
        drain_results();
        $display("covered %0d events and %0d results over all event types,", n_items, n_results);
        $display("random idling on both channels and a long output stall");
        if (errors == 0 && results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- usb_endpoint_dma_scheduler.f -----
src/uedma_pkg.sv
src/uedma_minsub.sv
src/usb_endpoint_dma_scheduler.sv
tb/sv/testbench.sv
